>>> sv/trpd_pkg.sv
// Shared types and constants for the trailing pad row detector.
`timescale 1ns / 1ps

package trpd_pkg;

    localparam int WIDTH_W = 15;            // row_width register width
    localparam int COL_W   = 14;            // column counter width
    localparam int OUTL_W  = 16;            // outlier counter width
    localparam int PIXC_W  = 15;            // bright / dark counter width
    localparam int RUN_W   = 16;            // row run counters, result fields

    localparam logic [WIDTH_W-1:0] MAX_WIDTH = 15'd16384;

    // gray band 128 +/- 5, allowed span inside the band
    localparam logic [7:0] BAND_LO   = 8'd123;
    localparam logic [7:0] BAND_HI   = 8'd133;
    localparam logic [7:0] BAND_SPAN = 8'd3;

    // luminance thresholds applied to r+g+b (3 * 235 and 3 * 128)
    localparam logic [9:0] BRIGHT_SUM = 10'd705;
    localparam logic [9:0] DARK_SUM   = 10'd384;

    // percentages; pad budget is 5 percent of 3 samples per pixel
    localparam logic [6:0] PCT       = 7'd100;
    localparam logic [4:0] PAD_PCT   = 5'd15;
    localparam logic [6:0] BLANK_PCT = 7'd97;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       page_end;
    } t_pixel;

    typedef struct packed {
        logic [RUN_W-1:0] pad_rows;
        logic [RUN_W-1:0] crop_rows;
    } t_result;

    // per-pixel classification
    typedef struct packed {
        logic [1:0] outliers;   // samples outside the gray band
        logic       band_seen;  // at least one sample in band
        logic [7:0] band_min;   // 255 when none in band
        logic [7:0] band_max;   // 0 when none in band
        logic       bright;
        logic       dark;
    } t_pix_class;

endpackage

>>> sv/trpd_pix_class.sv
// Per-pixel classification: gray band membership and luminance class.
`timescale 1ns / 1ps

module trpd_pix_class
    import trpd_pkg::*;
(
    input  t_pixel     i_pixel,
    output t_pix_class o_class
);

    always_comb begin
        logic [7:0] v [3];
        logic [9:0] sum;
        v[0] = i_pixel.red;
        v[1] = i_pixel.green;
        v[2] = i_pixel.blue;
        o_class.outliers  = 2'd0;
        o_class.band_seen = 1'b0;
        o_class.band_min  = 8'hFF;
        o_class.band_max  = 8'h00;
        for (int k = 0; k < 3; k++) begin
            if (v[k] < BAND_LO || v[k] > BAND_HI) begin
                o_class.outliers = o_class.outliers + 2'd1;
            end else begin
                o_class.band_seen = 1'b1;
                if (v[k] < o_class.band_min) o_class.band_min = v[k];
                if (v[k] > o_class.band_max) o_class.band_max = v[k];
            end
        end
        sum = 10'(i_pixel.red) + 10'(i_pixel.green) + 10'(i_pixel.blue);
        o_class.bright = (sum >= BRIGHT_SUM);
        o_class.dark   = (sum < DARK_SUM);
    end

endmodule

>>> sv/trpd_core.sv
// Input register, row accumulators, row classification and page run counters.
`timescale 1ns / 1ps

module trpd_core
    import trpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [WIDTH_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    input  t_pixel             i_pixel,
    output logic               o_in_stall,
    input  logic               i_buf_full,
    output logic               o_push,
    output t_result            o_result
);

    logic               r_valid;
    t_pixel             r_pix;
    logic [WIDTH_W-1:0] r_width;
    logic [COL_W-1:0]   r_col;
    logic [OUTL_W-1:0]  r_outl;
    logic [7:0]         r_bmin;
    logic [7:0]         r_bmax;
    logic               r_bseen;
    logic [PIXC_W-1:0]  r_bright;
    logic [PIXC_W-1:0]  r_dark;
    logic [RUN_W-1:0]   r_pad_run;
    logic [RUN_W-1:0]   r_blank_run;
    logic [RUN_W-1:0]   r_above;

    logic [WIDTH_W-1:0] n_width;
    logic [COL_W-1:0]   n_col;
    logic [OUTL_W-1:0]  n_outl;
    logic [7:0]         n_bmin;
    logic [7:0]         n_bmax;
    logic               n_bseen;
    logic [PIXC_W-1:0]  n_bright;
    logic [PIXC_W-1:0]  n_dark;
    logic [RUN_W-1:0]   n_pad_run;
    logic [RUN_W-1:0]   n_blank_run;
    logic [RUN_W-1:0]   n_above;

    t_pix_class         w_cls;
    logic               w_move;
    logic               w_fin;
    logic               w_pad;
    logic               w_blank;
    logic [OUTL_W:0]    w_outl_sum;
    logic [RUN_W:0]     w_crop_sum;

    trpd_pix_class u_class (
        .i_pixel (r_pix),
        .o_class (w_cls)
    );

    // a beat without a result never waits on the output side
    assign w_move     = r_valid && (!r_pix.page_end || !i_buf_full);
    assign o_in_stall = r_valid && !w_move;
    assign o_push     = w_move && r_pix.page_end;

    always_comb begin
        if (i_cfg_data == '0)          n_width = WIDTH_W'(1);
        else if (i_cfg_data > MAX_WIDTH) n_width = MAX_WIDTH;
        else                           n_width = i_cfg_data;
    end

    // accumulate this pixel, then close the row if it is full
    always_comb begin
        w_outl_sum = {1'b0, r_outl} + (OUTL_W+1)'(w_cls.outliers);
        n_outl     = w_outl_sum[OUTL_W] ? '1 : w_outl_sum[OUTL_W-1:0];
        n_bmin     = (w_cls.band_min < r_bmin) ? w_cls.band_min : r_bmin;
        n_bmax     = (w_cls.band_max > r_bmax) ? w_cls.band_max : r_bmax;
        n_bseen    = r_bseen | w_cls.band_seen;
        n_bright   = (w_cls.bright && r_bright != '1) ? r_bright + 1'b1 : r_bright;
        n_dark     = (w_cls.dark && r_dark != '1) ? r_dark + 1'b1 : r_dark;

        w_fin   = (({1'b0, r_col} + WIDTH_W'(1)) >= r_width);
        w_pad   = (23'(n_outl) * 23'(PCT) <= 23'(r_width) * 23'(PAD_PCT))
                  && n_bseen && ((n_bmax - n_bmin) <= BAND_SPAN);
        w_blank = (22'(n_bright) * 22'(PCT) >= 22'(r_width) * 22'(BLANK_PCT))
                  && (22'(n_dark) * 22'(PCT) <= 22'(r_width));

        n_col       = r_col + 1'b1;
        n_pad_run   = r_pad_run;
        n_blank_run = r_blank_run;
        n_above     = r_above;
        if (w_fin) begin
            n_col = '0;
            if (w_pad) begin
                if (r_pad_run == '0) n_above = r_blank_run;
                if (r_pad_run != '1) n_pad_run = r_pad_run + 1'b1;
            end else begin
                n_pad_run = '0;
                n_above   = '0;
            end
            if (w_blank) begin
                if (r_blank_run != '1) n_blank_run = r_blank_run + 1'b1;
            end else begin
                n_blank_run = '0;
            end
        end

        w_crop_sum         = {1'b0, n_pad_run} + {1'b0, n_above};
        o_result.pad_rows  = n_pad_run;
        if (n_pad_run == '0)          o_result.crop_rows = '0;
        else if (w_crop_sum[RUN_W])   o_result.crop_rows = '1;
        else                          o_result.crop_rows = w_crop_sum[RUN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_pix <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_W'(1);
        end else if (i_cfg_we) begin
            r_width <= n_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_move && r_pix.page_end)) begin
            r_col       <= '0;
            r_outl      <= '0;
            r_bmin      <= 8'hFF;
            r_bmax      <= '0;
            r_bseen     <= 1'b0;
            r_bright    <= '0;
            r_dark      <= '0;
            r_pad_run   <= '0;
            r_blank_run <= '0;
            r_above     <= '0;
        end else if (w_move) begin
            r_col       <= n_col;
            r_pad_run   <= n_pad_run;
            r_blank_run <= n_blank_run;
            r_above     <= n_above;
            if (w_fin) begin
                r_outl   <= '0;
                r_bmin   <= 8'hFF;
                r_bmax   <= '0;
                r_bseen  <= 1'b0;
                r_bright <= '0;
                r_dark   <= '0;
            end else begin
                r_outl   <= n_outl;
                r_bmin   <= n_bmin;
                r_bmax   <= n_bmax;
                r_bseen  <= n_bseen;
                r_bright <= n_bright;
                r_dark   <= n_dark;
            end
        end
    end

endmodule

>>> sv/trpd_out_buf.sv
// Two-entry result buffer; full flag is registered.
`timescale 1ns / 1ps

module trpd_out_buf
    import trpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_result
);

    logic [1:0] r_count;
    t_result    r_q0;
    t_result    r_q1;
    logic       w_pop;

    assign o_out_valid = (r_count != 2'd0);
    assign o_full      = (r_count == 2'd2);
    assign o_result    = r_q0;
    assign w_pop       = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= r_count + 2'(i_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_count == 2'd2) r_q0 <= r_q1;
            else if (i_push)     r_q0 <= i_data;
            if (i_push && r_count == 2'd2) r_q1 <= i_data;
        end else if (i_push) begin
            if (r_count == 2'd0) r_q0 <= i_data;
            else                 r_q1 <= i_data;
        end
    end

endmodule

>>> sv/trailing_pad_row_detector_unit.sv
// Top level of the trailing pad row detector.
`timescale 1ns / 1ps

// Channel   Direction  Beat       Handshake
// pixel     in         t_pixel    i_in_valid / o_in_stall
// result    out        t_result   o_out_valid / i_out_stall
// config    in         row_width  i_cfg_we (no read-back)
//
// One pixel per clock sustained while o_in_stall is low. A pixel is latched
// in the input register, and from there the row accumulators, row
// classification and run counters update in a single pass; a page_end pixel
// pushes one result into a two-entry output buffer.
// Reset (synchronous, active low) sets row_width to 1 and clears all counts.
// Output stalls back up into the input only when a page_end pixel meets a
// full output buffer; pixels that make no result never wait.

module trailing_pad_row_detector_unit
    import trpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [WIDTH_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    input  t_pixel             i_pixel,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_result            o_result
);

    logic    w_push;
    logic    w_buf_full;
    t_result w_core_result;

    trpd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_pixel    (i_pixel),
        .o_in_stall (o_in_stall),
        .i_buf_full (w_buf_full),
        .o_push     (w_push),
        .o_result   (w_core_result)
    );

    trpd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_data      (w_core_result),
        .o_full      (w_buf_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result)
    );

    // never push into a full buffer
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_buf_full)
        else $error("result pushed into full buffer");

    // input backs up only behind a full buffer
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> w_buf_full)
        else $error("input stalled with room in buffer");

    // no pad means no crop
    a_crop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result.pad_rows == '0) |-> (o_result.crop_rows == '0))
        else $error("crop rows without pad rows");

    // crop never below pad
    a_crop_ge_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_result.crop_rows >= o_result.pad_rows))
        else $error("crop rows below pad rows");

endmodule
